@@ rtl/core/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AREQ,
        S_ASCAN,
        S_AUNL,
        S_ASPLIT,
        S_AFIN,
        S_FRD,
        S_FCHK,
        S_MRD,
        S_MCHK,
        S_MPUSH,
        S_DONE
    } state_t;

    // Command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Register indexes
    localparam logic REG_MIN_ORDER = 1'b0;
    localparam logic REG_MAX_ORDER = 1'b1;

    // Field widths
    localparam int ORD_W   = 5;
    localparam int CUR_W   = 6;
    localparam int TAG_W   = 6;
    localparam int SIZE_W  = 17;
    localparam int TOT_W   = 17;
    localparam int BADDR_W = 16;
    localparam int RADDR_W = 16;
    localparam int CFG_W   = 5;

    // Control of the per-order list end table
    typedef struct packed {
        logic init;
        logic wr;
    } ends_op_t;

endpackage

`default_nettype wire

@@ rtl/core/bba_ends.sv @@
// ----------------------------------------------------------------------------
// bba_ends
// Per-order free list ends: head, tail and nonempty flag for each order.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ends
    import bba_pkg::*;
#(
    parameter int NORD = 17,
    parameter int IW   = 5,
    parameter int SW   = 12
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ends_op_t      op,
    input  wire logic [IW-1:0] init_idx,
    input  wire logic [IW-1:0] widx,
    input  wire logic [SW-1:0] whead,
    input  wire logic [SW-1:0] wtail,
    input  wire logic          wne,
    input  wire logic [IW-1:0] ridx,
    output logic      [SW-1:0] rhead,
    output logic      [SW-1:0] rtail,
    output logic               rne
);

    logic [SW-1:0] head_reg [NORD];
    logic [SW-1:0] tail_reg [NORD];
    logic [NORD-1:0] ne_reg;

    // Flags: init leaves only the top order holding slot 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg <= '0;
        end
        else if (op.init)
        begin
            for (int i = 0; i < NORD; i++)
            begin
                ne_reg[i] <= (IW'(i) == init_idx);
            end
        end
        else if (op.wr)
        begin
            ne_reg[widx] <= wne;
        end
    end

    // Head and tail pointers
    always_ff @(posedge clk)
    begin
        if (op.init)
        begin
            head_reg[init_idx] <= '0;
            tail_reg[init_idx] <= '0;
        end
        else if (op.wr)
        begin
            head_reg[widx] <= whead;
            tail_reg[widx] <= wtail;
        end
    end

    // Read one order; orders past the table read as empty
    always_comb
    begin
        if (32'(ridx) < NORD)
        begin
            rhead = head_reg[ridx];
            rtail = tail_reg[ridx];
            rne   = ne_reg[ridx];
        end
        else
        begin
            rhead = '0;
            rtail = '0;
            rne   = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/buddy_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Buddy allocator with per-slot tags and linked free lists in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis_*: tuser carries the command (allocate,
//   free, query), tdata the request size and block address. Each item gives
//   one result on m_axis_*: tuser is ok, tdata the address, order and totals.
//   cfg_we/cfg_index/cfg_data write the smallest block order (0) or the
//   total memory order (1); a write reinitializes the allocator.
//   Items are handled one at a time by a sequencer around single-port-read
//   RAMs with registered reads. Allocate rounds the size up from the
//   smallest order, scans the orders for a free block and splits it down;
//   free reads the block tag and merges the block with each free buddy;
//   query reads the tag; an unaligned address or an unused command goes
//   straight to the result. The sequencer returns to idle before it takes
//   the next item.
//   After reset and after each register write a clearing pass sweeps all
//   2^(ADDR_BITS-MIN_ORDER_FLOOR) slots (4096 by default), one per
//   cycle, with s_axis_tready low.
//   A finished result sits in an output register; if the receiver stalls,
//   the next item is accepted and worked on, and waits only to hand over.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int ADDR_BITS       = 16,
    parameter int MIN_ORDER_FLOOR = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Input items
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [39:0]      s_axis_tdata,   // req_size[16:0], block_addr[32:17], zeros
    input  wire logic [1:0]       s_axis_tuser,   // cmd[1:0]
    // Result items
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [55:0]      m_axis_tdata,   // result_addr[15:0], block_order[20:16],
                                                  // used_bytes[37:21], frag_bytes[54:38], zero
    output logic                  m_axis_tuser,   // ok
    // Configuration
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int AW     = ADDR_BITS;
    localparam int SW     = ADDR_BITS - MIN_ORDER_FLOOR;
    localparam int NSLOTS = 1 << SW;
    localparam int NORD   = ADDR_BITS + 1;
    localparam int IW     = $clog2(NORD);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   min_reg, min_next;
    logic [CFG_W-1:0]   max_reg, max_next;
    logic [SW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [BADDR_W-1:0] baddr_reg, baddr_next;
    logic [CUR_W-1:0]   req_reg, req_next;
    logic [CUR_W-1:0]   cur_reg, cur_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               res_ok_reg, res_ok_next;
    logic [RADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [ORD_W-1:0]   res_ord_reg, res_ord_next;
    logic [TOT_W-1:0]   used_reg, used_next;
    logic [TOT_W-1:0]   frag_reg, frag_next;
    logic               mval_reg, mval_next;
    logic               mok_reg, mok_next;
    logic [55:0]        mdata_reg, mdata_next;

    // Memories
    logic [TAG_W-1:0]  ftag_mem [NSLOTS];
    logic [SW-1:0]     nxt_mem  [NSLOTS];
    logic [SW-1:0]     prv_mem  [NSLOTS];
    logic [TAG_W-1:0]  atag_mem [NSLOTS];
    logic [SIZE_W-1:0] rsz_mem  [NSLOTS];

    logic              ftag_we, nxt_we, prv_we, atag_we, rsz_we;
    logic [SW-1:0]     ftag_wa, nxt_wa, prv_wa, atag_wa;
    logic [TAG_W-1:0]  ftag_wd, atag_wd;
    logic [SW-1:0]     nxt_wd, prv_wd;
    logic [SW-1:0]     nxt_ra;
    logic [TAG_W-1:0]  ftag_rd, atag_rd;
    logic [SW-1:0]     nxt_rd, prv_rd;
    logic [SIZE_W-1:0] rsz_rd;

    // List end table
    ends_op_t      ends_op;
    logic [IW-1:0] ends_ridx;
    logic [SW-1:0] ends_whead, ends_wtail, e_head, e_tail;
    logic          ends_wne, e_ne;

    logic [CUR_W-1:0] emin, emax, cur_m1, push_ord;
    logic [AW-1:0]    split_addr, buddy, addr_min;
    logic [SW-1:0]    split_slot, buddy_slot, addr_slot, push_slot;
    logic             push_en, addr_ok, bud_free_hit, req_small;
    logic [17:0]      bsize_a, bsize_f;

    // Effective orders clamped to the supported range
    always_comb
    begin
        if (CUR_W'(min_reg) < CUR_W'(MIN_ORDER_FLOOR))
            emin = CUR_W'(MIN_ORDER_FLOOR);
        else if (CUR_W'(min_reg) > CUR_W'(ADDR_BITS))
            emin = CUR_W'(ADDR_BITS);
        else
            emin = CUR_W'(min_reg);
        if (CUR_W'(max_reg) < CUR_W'(MIN_ORDER_FLOOR))
            emax = CUR_W'(MIN_ORDER_FLOOR);
        else if (CUR_W'(max_reg) > CUR_W'(ADDR_BITS))
            emax = CUR_W'(ADDR_BITS);
        else
            emax = CUR_W'(max_reg);
    end

    // Address arithmetic
    assign cur_m1     = cur_reg - CUR_W'(1);
    assign split_addr = (AW'(slot_reg) << MIN_ORDER_FLOOR) | (AW'(1) << cur_m1);
    assign split_slot = SW'(split_addr >> MIN_ORDER_FLOOR);
    assign buddy      = addr_reg ^ (AW'(1) << cur_reg);
    assign buddy_slot = SW'(buddy >> MIN_ORDER_FLOOR);
    assign addr_min   = (buddy < addr_reg) ? buddy : addr_reg;
    assign addr_slot  = SW'(addr_reg >> MIN_ORDER_FLOOR);
    assign addr_ok    = ((33'(baddr_reg) & ((33'(1) << MIN_ORDER_FLOOR) - 33'(1))) == '0)
                        && ((33'(baddr_reg) >> ADDR_BITS) == '0);
    assign bud_free_hit = (ftag_rd == {1'b1, ORD_W'(cur_reg)});
    assign req_small  = ((18'd1 << req_reg) < {1'b0, size_reg});
    assign bsize_a    = 18'd1 << req_reg;
    assign bsize_f    = 18'd1 << atag_rd[ORD_W-1:0];

    // Push target: split halves on allocate, merged block on free
    assign push_en   = ((state_reg == S_ASPLIT) && (cur_reg > req_reg))
                       || (state_reg == S_MPUSH);
    assign push_ord  = (state_reg == S_ASPLIT) ? cur_m1 : cur_reg;
    assign push_slot = (state_reg == S_ASPLIT) ? split_slot : addr_slot;
    assign ends_ridx = IW'(push_ord);

    // Read addresses
    assign nxt_ra = (state_reg == S_ASCAN) ? e_head : buddy_slot;

    bba_ends #(
        .NORD (NORD),
        .IW   (IW),
        .SW   (SW)
    ) u_ends (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (ends_op),
        .init_idx (IW'(emax)),
        .widx     (ends_ridx),
        .whead    (ends_whead),
        .wtail    (ends_wtail),
        .wne      (ends_wne),
        .ridx     (ends_ridx),
        .rhead    (e_head),
        .rtail    (e_tail),
        .rne      (e_ne)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (&clr_cnt_reg) state_next = S_IDLE;
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == CMD_ALLOC)
                        state_next = S_AREQ;
                    else if (s_axis_tuser inside {CMD_FREE, CMD_QUERY})
                        state_next = S_FRD;
                    else
                        state_next = S_DONE;
                end
            end
            S_AREQ:   if (!req_small) state_next = S_ASCAN;
            S_ASCAN:
            begin
                if (cur_reg > emax)
                    state_next = S_DONE;
                else if (e_ne)
                    state_next = S_AUNL;
            end
            S_AUNL:   state_next = S_ASPLIT;
            S_ASPLIT: if (cur_reg <= req_reg) state_next = S_AFIN;
            S_AFIN:   state_next = S_DONE;
            S_FRD:    state_next = addr_ok ? S_FCHK : S_DONE;
            S_FCHK:
            begin
                if (!atag_rd[TAG_W-1] || (cmd_reg == CMD_QUERY))
                    state_next = S_DONE;
                else
                    state_next = S_MRD;
            end
            S_MRD:    state_next = (cur_reg < emax) ? S_MCHK : S_MPUSH;
            S_MCHK:   state_next = bud_free_hit ? S_MRD : S_MPUSH;
            S_MPUSH:  state_next = S_DONE;
            S_DONE:   if (!mval_reg || m_axis_tready) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
        if (cfg_we)
            state_next = S_CLEAR;
    end

    // Datapath and memory controls
    always_comb
    begin
        min_next      = min_reg;
        max_next      = max_reg;
        clr_cnt_next  = clr_cnt_reg;
        cmd_next      = cmd_reg;
        size_next     = size_reg;
        baddr_next    = baddr_reg;
        req_next      = req_reg;
        cur_next      = cur_reg;
        slot_next     = slot_reg;
        addr_next     = addr_reg;
        res_ok_next   = res_ok_reg;
        res_addr_next = res_addr_reg;
        res_ord_next  = res_ord_reg;
        used_next     = used_reg;
        frag_next     = frag_reg;
        mval_next     = mval_reg && !m_axis_tready;
        mok_next      = mok_reg;
        mdata_next    = mdata_reg;
        ftag_we = 1'b0; ftag_wa = push_slot; ftag_wd = {1'b1, ORD_W'(push_ord)};
        atag_we = 1'b0; atag_wa = slot_reg;  atag_wd = '0;
        nxt_we  = 1'b0; nxt_wa  = e_tail;    nxt_wd  = push_slot;
        prv_we  = 1'b0; prv_wa  = push_slot; prv_wd  = e_tail;
        rsz_we  = 1'b0;
        ends_op    = '0;
        ends_whead = e_head;
        ends_wtail = e_tail;
        ends_wne   = e_ne;

        // Append a free block at the tail of its order list
        if (push_en)
        begin
            ftag_we    = 1'b1;
            ends_op.wr = 1'b1;
            ends_wtail = push_slot;
            ends_wne   = 1'b1;
            if (e_ne)
            begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
            end
            else
            begin
                ends_whead = push_slot;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep tags; slot 0 is the whole memory at the top order
                ftag_we      = 1'b1;
                ftag_wa      = clr_cnt_reg;
                ftag_wd      = (clr_cnt_reg == '0) ? {1'b1, ORD_W'(emax)} : '0;
                atag_we      = 1'b1;
                atag_wa      = clr_cnt_reg;
                ends_op.init = 1'b1;
                used_next    = '0;
                frag_next    = '0;
                clr_cnt_next = clr_cnt_reg + SW'(1);
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next      = s_axis_tuser;
                    size_next     = s_axis_tdata[16:0];
                    baddr_next    = s_axis_tdata[32:17];
                    slot_next     = SW'(33'(s_axis_tdata[32:17]) >> MIN_ORDER_FLOOR);
                    addr_next     = AW'(s_axis_tdata[32:17]);
                    req_next      = emin;
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                    res_ord_next  = '0;
                end
            end
            S_AREQ:
            begin
                if (req_small)
                    req_next = req_reg + CUR_W'(1);
                else
                    cur_next = req_reg;
            end
            S_ASCAN:
            begin
                slot_next = e_head;
                if ((cur_reg <= emax) && !e_ne)
                    cur_next = cur_reg + CUR_W'(1);
            end
            S_AUNL:
            begin
                // Unlink the list head
                ftag_we    = 1'b1;
                ftag_wa    = slot_reg;
                ftag_wd    = '0;
                ends_op.wr = 1'b1;
                if (e_tail == slot_reg)
                    ends_wne = 1'b0;
                else
                    ends_whead = nxt_rd;
            end
            S_ASPLIT:
            begin
                if (cur_reg > req_reg)
                    cur_next = cur_m1;
            end
            S_AFIN:
            begin
                atag_we       = 1'b1;
                atag_wd       = {1'b1, ORD_W'(req_reg)};
                rsz_we        = 1'b1;
                used_next     = used_reg + TOT_W'(bsize_a);
                frag_next     = frag_reg + TOT_W'(bsize_a - {1'b0, size_reg});
                res_ok_next   = 1'b1;
                res_addr_next = RADDR_W'(AW'(slot_reg) << MIN_ORDER_FLOOR);
                res_ord_next  = ORD_W'(req_reg);
            end
            S_FCHK:
            begin
                if (atag_rd[TAG_W-1] && (cmd_reg == CMD_QUERY))
                begin
                    res_ok_next  = 1'b1;
                    res_ord_next = atag_rd[ORD_W-1:0];
                end
                else if (atag_rd[TAG_W-1])
                begin
                    used_next = used_reg - TOT_W'(bsize_f);
                    frag_next = frag_reg - ((bsize_f >= {1'b0, rsz_rd})
                                ? TOT_W'(bsize_f - {1'b0, rsz_rd}) : '0);
                    atag_we   = 1'b1;
                    cur_next  = CUR_W'(atag_rd[ORD_W-1:0]);
                end
            end
            S_MCHK:
            begin
                if (bud_free_hit)
                begin
                    // Unlink the buddy from the list of its order
                    ftag_we    = 1'b1;
                    ftag_wa    = buddy_slot;
                    ftag_wd    = '0;
                    ends_op.wr = 1'b1;
                    if ((e_head == buddy_slot) && (e_tail == buddy_slot))
                        ends_wne = 1'b0;
                    else if (e_head == buddy_slot)
                        ends_whead = nxt_rd;
                    else if (e_tail == buddy_slot)
                        ends_wtail = prv_rd;
                    else
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_rd;
                        nxt_wd = nxt_rd;
                        prv_we = 1'b1;
                        prv_wa = nxt_rd;
                        prv_wd = prv_rd;
                    end
                    addr_next = addr_min;
                    cur_next  = cur_reg + CUR_W'(1);
                end
            end
            S_MPUSH:
            begin
                res_ok_next = 1'b1;
            end
            S_DONE:
            begin
                // Hand the result to the output register
                if (!mval_reg || m_axis_tready)
                begin
                    mval_next  = 1'b1;
                    mok_next   = res_ok_reg;
                    mdata_next = {1'b0, frag_reg, used_reg, res_ord_reg, res_addr_reg};
                end
            end
            default:
            begin
            end
        endcase

        // Register writes restart the clearing pass
        if (cfg_we)
        begin
            clr_cnt_next = '0;
            if (cfg_index == REG_MIN_ORDER)
                min_next = cfg_data;
            else if (cfg_index == REG_MAX_ORDER)
                max_next = cfg_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            min_reg     <= CFG_W'(4);
            max_reg     <= CFG_W'(16);
            mval_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            mval_reg    <= mval_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        size_reg     <= size_next;
        baddr_reg    <= baddr_next;
        req_reg      <= req_next;
        cur_reg      <= cur_next;
        slot_reg     <= slot_next;
        addr_reg     <= addr_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        res_ord_reg  <= res_ord_next;
        used_reg     <= used_next;
        frag_reg     <= frag_next;
        mok_reg      <= mok_next;
        mdata_reg    <= mdata_next;
    end

    // Memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (ftag_we)
            ftag_mem[ftag_wa] <= ftag_wd;
        ftag_rd <= ftag_mem[buddy_slot];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[nxt_wa] <= nxt_wd;
        nxt_rd <= nxt_mem[nxt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
            prv_mem[prv_wa] <= prv_wd;
        prv_rd <= prv_mem[buddy_slot];
    end

    always_ff @(posedge clk)
    begin
        if (atag_we)
            atag_mem[atag_wa] <= atag_wd;
        atag_rd <= atag_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rsz_we)
            rsz_mem[slot_reg] <= size_reg;
        rsz_rd <= rsz_mem[slot_reg];
    end

    // Ports
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tuser  = mok_reg;
    assign m_axis_tdata  = mdata_reg;

`ifndef SYNTH
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == S_CLEAR))
        else $error("register write did not start the clearing pass");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result presented outside the hand-over state");

    a_alloc_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AFIN) |-> ((req_reg >= emin) && (req_reg <= emax)))
        else $error("allocated order outside the configured range");

    a_merge_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MCHK) |-> (cur_reg < emax))
        else $error("buddy merge attempted at the top order");
`endif

endmodule

`default_nettype wire
